>>> rtl/core/cmdrl_pkg.sv
package cmdrl_pkg;

  localparam int unsigned StackDepthDefault = 256;
  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned OutqDepth = 4;

  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChIn    = 8'h2C;
  localparam logic [7:0] ChOut   = 8'h2E;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  typedef enum logic [3:0] {
    KIND_RIGHT  = 4'd0,
    KIND_LEFT   = 4'd1,
    KIND_INC    = 4'd2,
    KIND_DEC    = 4'd3,
    KIND_INPUT  = 4'd4,
    KIND_OUTPUT = 4'd5,
    KIND_OPEN   = 4'd6,
    KIND_CLOSE  = 4'd7,
    KIND_FINISH = 4'd8
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNMATCH  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_e;

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] count;
    logic [15:0] loop_num;
    err_code_e   err;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t res0;
    token_t res1;
  } tok_pair_t;

  function automatic token_kind_e run_kind(input logic [7:0] c);
    token_kind_e k;
    k = KIND_DEC;
    if (c == ChRight) begin
      k = KIND_RIGHT;
    end else if (c == ChLeft) begin
      k = KIND_LEFT;
    end else if (c == ChPlus) begin
      k = KIND_INC;
    end
    return k;
  endfunction

endpackage

>>> rtl/core/command_run_length_loop_matcher.sv
// Channel  Handshake                 Payload
// input    in_valid_i/in_ready_o     program_byte_i, end_of_program_i
// output   out_valid_o/out_ready_i   token_kind_o .. last_of_run_o, five fields
//
// One input transaction is taken per cycle while input ready is high. Its tokens are
// registered in the front stage, together with the registered read of the loop stack memory,
// and are then written into the output queue, from which the first of them can leave.
// A transaction yields up to two tokens; output drains one per cycle when not stalled.
// Input ready drops when the four-entry output queue, counting the tokens still in the
// pipeline register, could not hold two more tokens.
// Reset clears run, loop and queue pointer state; the stack and queue memories need no clearing.
module command_run_length_loop_matcher import cmdrl_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  program_byte_i,
  input  logic        end_of_program_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] repeat_count_o,
  output logic [15:0] loop_number_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  logic                           push;
  logic                           pop;
  logic [$clog2(STACK_DEPTH)-1:0] addr;
  logic [15:0]                    wdata;
  logic [15:0]                    rdata;
  tok_pair_t                      pair;
  token_t                         tok;
  logic                           room;

  assign in_ready_o = room;

  cmdrl_front #(
    .STACK_DEPTH(STACK_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (in_valid_i && room),
    .program_byte_i,
    .end_of_program_i,
    .push_o          (push),
    .pop_o           (pop),
    .addr_o          (addr),
    .wdata_o         (wdata),
    .rdata_i         (rdata),
    .pair_o          (pair)
  );

  cmdrl_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i,
    .push_i  (push),
    .pop_i   (pop),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  cmdrl_outq u_outq (
    .clk_i,
    .rst_ni,
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .tok_o   (tok)
  );

  assign token_kind_o   = tok.kind;
  assign repeat_count_o = tok.count;
  assign loop_number_o  = tok.loop_num;
  assign error_code_o   = tok.err;
  assign last_of_run_o  = tok.last;

endmodule

>>> rtl/core/cmdrl_stack.sv
module cmdrl_stack import cmdrl_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           push_i,
  input  logic                           pop_i,
  input  logic [$clog2(STACK_DEPTH)-1:0] addr_i,
  input  logic [15:0]                    wdata_i,
  output logic [15:0]                    rdata_o
);

  logic [15:0] mem_q [STACK_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cmdrl_front.sv
module cmdrl_front import cmdrl_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [7:0]                     program_byte_i,
  input  logic                           end_of_program_i,
  output logic                           push_o,
  output logic                           pop_o,
  output logic [$clog2(STACK_DEPTH)-1:0] addr_o,
  output logic [15:0]                    wdata_o,
  input  logic [15:0]                    rdata_i,
  output tok_pair_t                      pair_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned FillW = $clog2(STACK_DEPTH + 1);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [FillW-1:0] FillFull = FillW'(STACK_DEPTH);

  logic [7:0]             char_q, char_d;
  logic [COUNT_WIDTH-1:0] len_q, len_d;
  logic                   pending_q, pending_d;
  logic                   cell_q, cell_d;
  logic [15:0]            dead_q, dead_d;
  logic [15:0]            next_q, next_d;
  logic [FillW-1:0]       fill_q, fill_d;
  tok_pair_t              pair_q, pair_d;
  logic                   pop_q;
  logic                   flush;
  logic                   is_dead;

  assign flush   = pending_q && (program_byte_i != char_q || len_q == CountMax);
  assign is_dead = dead_q != 16'd0;

  always_comb begin
    char_d    = char_q;
    len_d     = len_q;
    pending_d = pending_q;
    cell_d    = cell_q;
    dead_d    = dead_q;
    next_d    = next_q;
    fill_d    = fill_q;
    pair_d    = '0;
    push_o    = 1'b0;
    pop_o     = 1'b0;
    addr_o    = AddrW'(fill_q);
    wdata_o   = next_q;
    if (accept_i) begin
      if (end_of_program_i) begin
        if (pending_q) begin
          pair_d.v0         = 1'b1;
          pair_d.res0.kind  = run_kind(char_q);
          pair_d.res0.count = 16'(len_q);
        end
        pair_d.v1        = 1'b1;
        pair_d.res1.kind = KIND_FINISH;
        char_d    = '0;
        len_d     = '0;
        pending_d = 1'b0;
        cell_d    = 1'b0;
        dead_d    = '0;
        next_d    = '0;
        fill_d    = '0;
      end else begin
        if (flush) begin
          pair_d.v0         = 1'b1;
          pair_d.res0.kind  = run_kind(char_q);
          pair_d.res0.count = 16'(len_q);
          pending_d = 1'b0;
          len_d     = '0;
          char_d    = '0;
        end
        if (!is_dead || program_byte_i == ChOpen || program_byte_i == ChClose) begin
          unique case (program_byte_i)
            ChPlus, ChMinus, ChRight, ChLeft: begin
              if (program_byte_i == ChPlus || program_byte_i == ChMinus) begin
                cell_d = 1'b1;
              end
              if (pending_q && !flush) begin
                len_d = len_q + 1'b1;
              end else begin
                pending_d = 1'b1;
                char_d    = program_byte_i;
                len_d     = COUNT_WIDTH'(1);
              end
            end
            ChIn: begin
              cell_d           = 1'b1;
              pair_d.v1        = 1'b1;
              pair_d.res1.kind = KIND_INPUT;
            end
            ChOut: begin
              pair_d.v1        = 1'b1;
              pair_d.res1.kind = KIND_OUTPUT;
            end
            ChOpen: begin
              if (is_dead || !cell_q) begin
                if (dead_q != 16'hFFFF) begin
                  dead_d = dead_q + 16'd1;
                end
              end else begin
                pair_d.v1            = 1'b1;
                pair_d.res1.kind     = KIND_OPEN;
                pair_d.res1.loop_num = next_q;
                if (fill_q == FillFull) begin
                  pair_d.res1.err = ERR_OVERFLOW;
                end else begin
                  push_o = 1'b1;
                  fill_d = fill_q + 1'b1;
                  next_d = next_q + 16'd1;
                end
              end
            end
            ChClose: begin
              if (is_dead) begin
                dead_d = dead_q - 16'd1;
              end else begin
                pair_d.v1        = 1'b1;
                pair_d.res1.kind = KIND_CLOSE;
                if (fill_q == '0) begin
                  pair_d.res1.err = ERR_UNMATCH;
                end else begin
                  pop_o  = 1'b1;
                  fill_d = fill_q - 1'b1;
                  addr_o = AddrW'(fill_q - 1'b1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      pair_d.res0.last = !pair_d.v1;
      pair_d.res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q    <= '0;
      len_q     <= '0;
      pending_q <= 1'b0;
      cell_q    <= 1'b0;
      dead_q    <= '0;
      next_q    <= '0;
      fill_q    <= '0;
      pair_q    <= '0;
      pop_q     <= 1'b0;
    end else begin
      char_q    <= char_d;
      len_q     <= len_d;
      pending_q <= pending_d;
      cell_q    <= cell_d;
      dead_q    <= dead_d;
      next_q    <= next_d;
      fill_q    <= fill_d;
      pair_q    <= pair_d;
      pop_q     <= pop_o;
    end
  end

  always_comb begin
    pair_o = pair_q;
    if (pop_q) begin
      pair_o.res1.loop_num = rdata_i;
    end
  end

endmodule

>>> rtl/core/cmdrl_outq.sv
module cmdrl_outq import cmdrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_pair_t pair_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output token_t    tok_o
);

  localparam int unsigned PtrW = $clog2(OutqDepth);
  localparam int unsigned CntW = $clog2(OutqDepth + 1);

  token_t          buf_q [OutqDepth];
  logic [PtrW-1:0] wp_q, wp_d;
  logic [PtrW-1:0] rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_in;
  logic            pop;

  assign n_in    = CntW'(pair_i.v0) + CntW'(pair_i.v1);
  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign tok_o   = buf_q[rp_q];
  assign room_o  = (cnt_q + n_in) <= CntW'(OutqDepth - 2);

  always_comb begin
    wp_d  = wp_q + PtrW'(n_in);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + n_in - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.v0) begin
      buf_q[wp_q] <= pair_i.res0;
    end
    if (pair_i.v1) begin
      buf_q[wp_q + PtrW'(pair_i.v0)] <= pair_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
